// File: rtl/slist_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// sequential list engine. No dependencies; imported by the controller, datapath and top level.
package slist_pkg;

    // field widths
    localparam int OP_W      = 2;
    localparam int VAL_W     = 32;
    localparam int IDX_W     = 8;
    localparam int POS_W     = 8;
    localparam int CNT_W     = 9;
    localparam int CAP_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 9;

    localparam int DEPTH_DEF = 256;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_REMV   = 2'd2;
    localparam logic [OP_W-1:0] OP_REMI   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_SORTED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 1'b1;

    typedef enum logic [2:0] {
        CUR_HOLD, CUR_ZERO, CUR_COUNT, CUR_POS, CUR_INC, CUR_DEC, CUR_MID_P1
    } cur_op_t;

    typedef enum logic [1:0] {HI_HOLD, HI_COUNT, HI_MID} hi_op_t;

    typedef enum logic [2:0] {
        POS_HOLD, POS_COUNT, POS_CUR, POS_MID, POS_IDX
    } pos_op_t;

    typedef enum logic [2:0] {RA_CUR_M1, RA_CUR, RA_CUR_P1, RA_MID, RA_LAST} raddr_sel_t;

    typedef enum logic [1:0] {WA_CUR, WA_COUNT, WA_POS} waddr_sel_t;

    typedef enum logic {WD_VALUE, WD_RDATA} wdata_sel_t;

    typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC} cnt_op_t;

    typedef struct packed {
        logic       load_req;
        cur_op_t    cur_op;
        hi_op_t     hi_op;
        pos_op_t    pos_op;
        raddr_sel_t raddr_sel;
        logic       we;
        waddr_sel_t waddr_sel;
        wdata_sel_t wdata_sel;
        cnt_op_t    cnt_op;
        logic       set_ok;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            keep_sorted;
        logic            room;
        logic            idx_ok;
        logic            cur_zero;
        logic            cur_lt_count;
        logic            cur_p1_lt_count;
        logic            lo_lt_hi;
        logic            rd_eq;
        logic            v_lt_rd;
        logic            rd_lt_v;
        logic            out_free;
    } sts_t;

endpackage

// File: rtl/slist_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module slist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/slist_dp.sv
// Datapath: config registers, request latch, cursors, entry count, list RAM
// and result register. Depends on slist_pkg and slist_ram.
module slist_dp #(
    parameter int DEPTH = slist_pkg::DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [slist_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [slist_pkg::CFG_W-1:0]       cfg_data,
    input  logic [slist_pkg::OP_W-1:0]        op,
    input  logic signed [slist_pkg::VAL_W-1:0] value,
    input  logic [slist_pkg::IDX_W-1:0]       index,
    input  logic                              rsp_stall,
    output logic                              rsp_valid,
    output logic                              ok,
    output logic [slist_pkg::POS_W-1:0]       position,
    output logic [slist_pkg::CNT_W-1:0]       count,
    input  slist_pkg::cmd_t                   cmd,
    output slist_pkg::sts_t                   sts
);

    import slist_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;
    localparam int IW = (CW > IDX_W) ? CW : IDX_W;

    logic                 keep_sorted_reg, keep_sorted_next;
    logic [CAP_W-1:0]     capacity_reg, capacity_next;
    logic [OP_W-1:0]      op_reg;
    logic [VAL_W-1:0]     value_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        cur_reg, cur_next;
    logic [CW-1:0]        hi_reg, hi_next;
    logic [AW-1:0]        pos_reg, pos_next;
    logic                 ok_flag_reg, ok_flag_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic                 rsp_ok_reg;
    logic [POS_W-1:0]     rsp_pos_reg;
    logic [CNT_W-1:0]     rsp_cnt_reg;

    logic [CW:0]          mid_sum;
    logic [AW-1:0]        mid;
    logic [AW-1:0]        raddr, waddr;
    logic [VAL_W-1:0]     wdata, rdata;

    // floor((lo + hi - 1) / 2); lo < hi whenever it is used
    assign mid_sum = {1'b0, cur_reg} + {1'b0, hi_reg} - {{CW{1'b0}}, 1'b1};
    assign mid     = mid_sum[AW:1];

    always_comb
    begin
        case (cmd.raddr_sel)
            RA_CUR_M1: raddr = AW'(cur_reg - CW'(1));
            RA_CUR:    raddr = AW'(cur_reg);
            RA_CUR_P1: raddr = AW'(cur_reg + CW'(1));
            RA_MID:    raddr = mid;
            RA_LAST:   raddr = AW'(count_reg - CW'(1));
            default:   raddr = AW'(cur_reg);
        endcase
        case (cmd.waddr_sel)
            WA_CUR:   waddr = AW'(cur_reg);
            WA_COUNT: waddr = AW'(count_reg);
            WA_POS:   waddr = pos_reg;
            default:  waddr = AW'(cur_reg);
        endcase
        wdata = (cmd.wdata_sel == WD_RDATA) ? rdata : value_reg;
    end

    slist_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        keep_sorted_next = keep_sorted_reg;
        capacity_next    = capacity_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_KEEP_SORTED: keep_sorted_next = cfg_data[0];
                CFG_CAPACITY:    capacity_next    = cfg_data[CAP_W-1:0];
                default:         keep_sorted_next = keep_sorted_reg;
            endcase
        end

        case (cmd.cur_op)
            CUR_ZERO:   cur_next = '0;
            CUR_COUNT:  cur_next = count_reg;
            CUR_POS:    cur_next = CW'(pos_reg);
            CUR_INC:    cur_next = cur_reg + CW'(1);
            CUR_DEC:    cur_next = cur_reg - CW'(1);
            CUR_MID_P1: cur_next = CW'(mid) + CW'(1);
            default:    cur_next = cur_reg;
        endcase

        case (cmd.hi_op)
            HI_COUNT: hi_next = count_reg;
            HI_MID:   hi_next = CW'(mid);
            default:  hi_next = hi_reg;
        endcase

        case (cmd.pos_op)
            POS_COUNT: pos_next = AW'(count_reg);
            POS_CUR:   pos_next = AW'(cur_reg);
            POS_MID:   pos_next = mid;
            POS_IDX:   pos_next = AW'(idx_reg);
            default:   pos_next = pos_reg;
        endcase
        if (cmd.load_req)
        begin
            pos_next = '0;
        end

        case (cmd.cnt_op)
            CNT_INC: count_next = count_reg + CW'(1);
            CNT_DEC: count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase

        ok_flag_next = ok_flag_reg;
        if (cmd.load_req)
        begin
            ok_flag_next = 1'b0;
        end
        else if (cmd.set_ok)
        begin
            ok_flag_next = 1'b1;
        end

        rsp_valid_next = rsp_valid_reg;
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_sorted_reg <= 1'b0;
            capacity_reg    <= CAP_RESET;
            count_reg       <= '0;
            ok_flag_reg     <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            keep_sorted_reg <= keep_sorted_next;
            capacity_reg    <= capacity_next;
            count_reg       <= count_next;
            ok_flag_reg     <= ok_flag_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            op_reg    <= op;
            value_reg <= value;
            idx_reg   <= index;
        end
        cur_reg <= cur_next;
        hi_reg  <= hi_next;
        pos_reg <= pos_next;
        if (cmd.out_load)
        begin
            rsp_ok_reg  <= ok_flag_reg;
            rsp_pos_reg <= ok_flag_reg ? POS_W'(pos_reg) : '0;
            rsp_cnt_reg <= CNT_W'(count_reg);
        end
    end

    always_comb
    begin
        sts.op              = op_reg;
        sts.keep_sorted     = keep_sorted_reg;
        sts.room            = (count_reg < CW'(DEPTH)) &&
                              (LW'(count_reg) < LW'(capacity_reg));
        sts.idx_ok          = IW'(idx_reg) < IW'(count_reg);
        sts.cur_zero        = (cur_reg == '0);
        sts.cur_lt_count    = cur_reg < count_reg;
        sts.cur_p1_lt_count = (cur_reg + CW'(1)) < count_reg;
        sts.lo_lt_hi        = cur_reg < hi_reg;
        sts.rd_eq           = rdata == value_reg;
        sts.v_lt_rd         = $signed(value_reg) < $signed(rdata);
        sts.rd_lt_v         = $signed(rdata) < $signed(value_reg);
        sts.out_free        = !rsp_valid_reg || !rsp_stall;
    end

    assign rsp_valid = rsp_valid_reg;
    assign ok        = rsp_ok_reg;
    assign position  = rsp_pos_reg;
    assign count     = rsp_cnt_reg;

endmodule

// File: rtl/slist_ctrl.sv
// Controller state machine: sequences RAM reads and writes for each list
// operation. Depends on slist_pkg.
module slist_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  slist_pkg::sts_t sts,
    output slist_pkg::cmd_t cmd
);

    import slist_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_INS_RD   = 4'd2;
    localparam logic [3:0] S_INS_CMP  = 4'd3;
    localparam logic [3:0] S_BS_RD    = 4'd4;
    localparam logic [3:0] S_BS_CMP   = 4'd5;
    localparam logic [3:0] S_LS_RD    = 4'd6;
    localparam logic [3:0] S_LS_CMP   = 4'd7;
    localparam logic [3:0] S_RM_START = 4'd8;
    localparam logic [3:0] S_RMS_RD   = 4'd9;
    localparam logic [3:0] S_RMS_WR   = 4'd10;
    localparam logic [3:0] S_RMU_WR   = 4'd11;
    localparam logic [3:0] S_FINISH   = 4'd12;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd.load_req  = 1'b0;
        cmd.cur_op    = CUR_HOLD;
        cmd.hi_op     = HI_HOLD;
        cmd.pos_op    = POS_HOLD;
        cmd.raddr_sel = RA_CUR;
        cmd.we        = 1'b0;
        cmd.waddr_sel = WA_CUR;
        cmd.wdata_sel = WD_VALUE;
        cmd.cnt_op    = CNT_HOLD;
        cmd.set_ok    = 1'b0;
        cmd.out_load  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.op)
                    OP_INSERT:
                    begin
                        if (!sts.room)
                        begin
                            state_next = S_FINISH;
                        end
                        else if (sts.keep_sorted)
                        begin
                            cmd.cur_op = CUR_COUNT;
                            state_next = S_INS_RD;
                        end
                        else
                        begin
                            // append
                            cmd.we        = 1'b1;
                            cmd.waddr_sel = WA_COUNT;
                            cmd.pos_op    = POS_COUNT;
                            cmd.cnt_op    = CNT_INC;
                            cmd.set_ok    = 1'b1;
                            state_next    = S_FINISH;
                        end
                    end
                    OP_SEARCH, OP_REMV:
                    begin
                        cmd.cur_op = CUR_ZERO;
                        if (sts.keep_sorted)
                        begin
                            cmd.hi_op  = HI_COUNT;
                            state_next = S_BS_RD;
                        end
                        else
                        begin
                            state_next = S_LS_RD;
                        end
                    end
                    default:
                    begin
                        if (sts.idx_ok)
                        begin
                            cmd.pos_op = POS_IDX;
                            state_next = S_RM_START;
                        end
                        else
                        begin
                            state_next = S_FINISH;
                        end
                    end
                endcase
            end
            S_INS_RD:
            begin
                if (sts.cur_zero)
                begin
                    cmd.we     = 1'b1;
                    cmd.pos_op = POS_CUR;
                    cmd.cnt_op = CNT_INC;
                    cmd.set_ok = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.raddr_sel = RA_CUR_M1;
                    state_next    = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                if (sts.v_lt_rd)
                begin
                    // shift larger entry up one place
                    cmd.we        = 1'b1;
                    cmd.wdata_sel = WD_RDATA;
                    cmd.cur_op    = CUR_DEC;
                    state_next    = S_INS_RD;
                end
                else
                begin
                    cmd.we     = 1'b1;
                    cmd.pos_op = POS_CUR;
                    cmd.cnt_op = CNT_INC;
                    cmd.set_ok = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_BS_RD:
            begin
                if (sts.lo_lt_hi)
                begin
                    cmd.raddr_sel = RA_MID;
                    state_next    = S_BS_CMP;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_BS_CMP:
            begin
                if (sts.rd_eq)
                begin
                    cmd.pos_op = POS_MID;
                    if (sts.op == OP_SEARCH)
                    begin
                        cmd.set_ok = 1'b1;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_RM_START;
                    end
                end
                else if (sts.rd_lt_v)
                begin
                    cmd.cur_op = CUR_MID_P1;
                    state_next = S_BS_RD;
                end
                else
                begin
                    cmd.hi_op  = HI_MID;
                    state_next = S_BS_RD;
                end
            end
            S_LS_RD:
            begin
                if (sts.cur_lt_count)
                begin
                    cmd.raddr_sel = RA_CUR;
                    state_next    = S_LS_CMP;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_LS_CMP:
            begin
                if (sts.rd_eq)
                begin
                    cmd.pos_op = POS_CUR;
                    if (sts.op == OP_SEARCH)
                    begin
                        cmd.set_ok = 1'b1;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_RM_START;
                    end
                end
                else
                begin
                    cmd.cur_op = CUR_INC;
                    state_next = S_LS_RD;
                end
            end
            S_RM_START:
            begin
                if (sts.keep_sorted)
                begin
                    cmd.cur_op = CUR_POS;
                    state_next = S_RMS_RD;
                end
                else
                begin
                    cmd.raddr_sel = RA_LAST;
                    state_next    = S_RMU_WR;
                end
            end
            S_RMS_RD:
            begin
                if (sts.cur_p1_lt_count)
                begin
                    cmd.raddr_sel = RA_CUR_P1;
                    state_next    = S_RMS_WR;
                end
                else
                begin
                    cmd.cnt_op = CNT_DEC;
                    cmd.set_ok = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_RMS_WR:
            begin
                cmd.we        = 1'b1;
                cmd.wdata_sel = WD_RDATA;
                cmd.cur_op    = CUR_INC;
                state_next    = S_RMS_RD;
            end
            S_RMU_WR:
            begin
                // last entry fills the hole
                cmd.we        = 1'b1;
                cmd.waddr_sel = WA_POS;
                cmd.wdata_sel = WD_RDATA;
                cmd.cnt_op    = CNT_DEC;
                cmd.set_ok    = 1'b1;
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

endmodule

// File: rtl/sequential_list_engine_top.sv
// Top level of the sequential list engine: bounded list of signed words with
// sorted and unsorted variants. Depends on slist_pkg, slist_ctrl, slist_dp.
//
//   channel   direction  handshake             payload
//   request   in         req_valid/req_stall   op, value, index
//   response  out        rsp_valid/rsp_stall   ok, position, count
//   config    in         cfg_we                cfg_index, cfg_data
//
// One request is worked at a time; each request gives one response.
// Every list step is an address step, then a data step, on the registered-read RAM.
// A request goes through accept, dispatch and finish, plus a list step per entry
// walked and a closing step: entries shifted on insert/remove, scanned on linear
// search, probed on binary search.
// Worst case is a sorted remove by value of the first of DEPTH entries.
// Reset clears the entry count, response valid and controller state and sets the config registers to their defaults;
// the RAM is not cleared. A new request is taken as soon as the previous one has its result in the
// response register, even while rsp_stall holds that result; a later result
// waits in the finish step until the response register frees up.
module sequential_list_engine_top #(
    parameter int DEPTH = slist_pkg::DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [slist_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [slist_pkg::CFG_W-1:0]        cfg_data,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic [slist_pkg::OP_W-1:0]         op,
    input  logic signed [slist_pkg::VAL_W-1:0] value,
    input  logic [slist_pkg::IDX_W-1:0]        index,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic                               ok,
    output logic [slist_pkg::POS_W-1:0]        position,
    output logic [slist_pkg::CNT_W-1:0]        count
);

    import slist_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer
    slist_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // storage, cursors and result register
    slist_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .op        (op),
        .value     (value),
        .index     (index),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .ok        (ok),
        .position  (position),
        .count     (count),
        .cmd       (cmd),
        .sts       (sts)
    );

    // no RAM write in the cycle a request is taken
    a_no_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |-> !cmd.we)
        else $error("RAM write while accepting a request");

    // a pending response is never overwritten
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("response register overwritten");

    // count only grows when the list has room
    a_inc_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.cnt_op == CNT_INC) |-> sts.room)
        else $error("entry count raised past capacity");

    // a response appears only after the controller loads one
    a_rsp_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(cmd.out_load))
        else $error("response valid without a load");

endmodule
